>>> rtl/csrsag_pkg.sv
// ----------------------------------------------------------------------------
// csrsag_pkg
// Shared types and constants for the row-compressed scatter address generator.
// ----------------------------------------------------------------------------
package csrsag_pkg;

  localparam int unsigned ROW_ENTRIES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned CMD_W   = 1;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ADDR_W  = 48;

  // log2 of the bytes in one stored value
  localparam int unsigned VALUE_SHIFT = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_ADDR
  } back_state_t;

endpackage

>>> rtl/csrsag_front.sv
// ----------------------------------------------------------------------------
// csrsag_front
// Input side: takes transactions, drops rows out of range and packs the rest
// into queue entries.
// ----------------------------------------------------------------------------
module csrsag_front #(
  parameter int unsigned ROW_ENTRIES = csrsag_pkg::ROW_ENTRIES_DEF,
  localparam int unsigned ROW_AW     = $clog2(ROW_ENTRIES),
  localparam int unsigned ENTRY_W    = csrsag_pkg::CMD_W + ROW_AW + csrsag_pkg::WORD_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [csrsag_pkg::CMD_W-1:0]    in_cmd,
  input  logic [csrsag_pkg::ROW_W-1:0]    in_row_index,
  input  logic [csrsag_pkg::WORD_W-1:0]   in_row_start,
  input  logic [csrsag_pkg::WORD_W-1:0]   in_value,
  input  logic                            q_full_i,
  input  logic                            clearing_i,
  output logic                            push_o,
  output logic [ENTRY_W-1:0]              push_data_o
);

  logic [31:0]                    row_ext;
  logic                           in_range;
  logic [ROW_AW-1:0]              row_idx;
  logic [csrsag_pkg::WORD_W-1:0]  payload;
  csrsag_pkg::cmd_t               cmd;

  assign row_ext  = 32'(in_row_index);
  assign in_range = row_ext < 32'(ROW_ENTRIES);
  assign row_idx  = row_ext[ROW_AW-1:0];
  assign cmd      = csrsag_pkg::cmd_t'(in_cmd);

  // only one of the two words matters per command, so they share a slot
  assign payload  = (cmd == csrsag_pkg::CMD_LOAD) ? in_row_start : in_value;

  assign in_ready    = !q_full_i && !clearing_i;
  assign push_o      = in_valid && in_ready && in_range;
  assign push_data_o = {cmd, row_idx, payload};

  property p_no_push_while_clearing;
    @(posedge clk) disable iff (!rst_n) clearing_i |-> !push_o;
  endproperty
  a_no_push_while_clearing: assert property (p_no_push_while_clearing)
    else $error("queue push during clearing pass");

  property p_no_push_when_full;
    @(posedge clk) disable iff (!rst_n) q_full_i |-> !push_o;
  endproperty
  a_no_push_when_full: assert property (p_no_push_when_full)
    else $error("queue push while full");

  property p_out_of_range_dropped;
    @(posedge clk) disable iff (!rst_n) (in_valid && !in_range) |-> !push_o;
  endproperty
  a_out_of_range_dropped: assert property (p_out_of_range_dropped)
    else $error("out-of-range row reached the queue");

endmodule

>>> rtl/csrsag_queue.sv
// ----------------------------------------------------------------------------
// csrsag_queue
// Short register FIFO decoupling the input side from the address side.
// ----------------------------------------------------------------------------
module csrsag_queue #(
  parameter int unsigned DATA_W = 1,
  parameter int unsigned DEPTH  = csrsag_pkg::QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] head_o,
  output logic              full_o,
  output logic              empty_o
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full_o  = cnt_r == CNT_W'(DEPTH);
  assign empty_o = cnt_r == '0;
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) full_o |-> !push_i;
  endproperty
  a_no_overflow: assert property (p_no_overflow)
    else $error("push into full queue");

  property p_no_underflow;
    @(posedge clk) disable iff (!rst_n) empty_o |-> !pop_i;
  endproperty
  a_no_underflow: assert property (p_no_underflow)
    else $error("pop from empty queue");

  property p_count_tracks;
    @(posedge clk) disable iff (!rst_n)
      (push_i && !pop_i) |=> cnt_r == $past(cnt_r) + 1'b1;
  endproperty
  a_count_tracks: assert property (p_count_tracks)
    else $error("queue fill level lost a push");

endmodule

>>> rtl/csrsag_back.sv
// ----------------------------------------------------------------------------
// csrsag_back
// Address side: holds the row start and fill count tables, runs the clearing
// pass after reset and forms write addresses into the output register.
// ----------------------------------------------------------------------------
module csrsag_back #(
  parameter int unsigned ROW_ENTRIES = csrsag_pkg::ROW_ENTRIES_DEF,
  localparam int unsigned ROW_AW     = $clog2(ROW_ENTRIES),
  localparam int unsigned ENTRY_W    = csrsag_pkg::CMD_W + ROW_AW + csrsag_pkg::WORD_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ENTRY_W-1:0]             head_i,
  input  logic                           q_empty_i,
  output logic                           pop_o,
  output logic                           clearing_o,
  input  logic [csrsag_pkg::ADDR_W-1:0]  base_i,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [csrsag_pkg::ADDR_W-1:0]  out_wr_addr,
  output logic [csrsag_pkg::WORD_W-1:0]  out_write_data
);

  localparam int unsigned WORD_W = csrsag_pkg::WORD_W;
  localparam int unsigned ADDR_W = csrsag_pkg::ADDR_W;
  localparam int unsigned ELEM_W = WORD_W + 1;

  csrsag_pkg::back_state_t state_r, state_nxt;

  csrsag_pkg::cmd_t   head_cmd;
  logic [ROW_AW-1:0]  head_idx;
  logic [WORD_W-1:0]  head_data;

  logic [WORD_W-1:0]  start_mem [ROW_ENTRIES];
  logic [WORD_W-1:0]  cnt_mem   [ROW_ENTRIES];
  logic [WORD_W-1:0]  start_q;
  logic [WORD_W-1:0]  cnt_q;

  logic [ROW_AW-1:0]  clr_idx_r, clr_idx_nxt;
  logic               clr_last;
  logic [ROW_AW-1:0]  cur_idx_r;
  logic [WORD_W-1:0]  cur_data_r;
  logic [ELEM_W-1:0]  elem_r;

  logic               ld_we;
  logic               rd_en;
  logic               cnt_we;
  logic [ROW_AW-1:0]  cnt_waddr;
  logic [WORD_W-1:0]  cnt_wdata;
  logic               out_load;
  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  addr_nxt;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [WORD_W-1:0]  out_data_r;

  assign head_cmd  = csrsag_pkg::cmd_t'(head_i[ENTRY_W-1 -: csrsag_pkg::CMD_W]);
  assign head_idx  = head_i[WORD_W +: ROW_AW];
  assign head_data = head_i[WORD_W-1:0];
  assign clr_last  = clr_idx_r == ROW_AW'(ROW_ENTRIES - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csrsag_pkg::ST_CLEAR: if (clr_last) state_nxt = csrsag_pkg::ST_IDLE;
      csrsag_pkg::ST_IDLE:  if (rd_en) state_nxt = csrsag_pkg::ST_SUM;
      csrsag_pkg::ST_SUM:   state_nxt = csrsag_pkg::ST_ADDR;
      csrsag_pkg::ST_ADDR:  if (out_load) state_nxt = csrsag_pkg::ST_IDLE;
      default:              state_nxt = csrsag_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    pop_o      = 1'b0;
    ld_we      = 1'b0;
    rd_en      = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = cur_idx_r;
    cnt_wdata  = cnt_q + 1'b1;
    out_load   = 1'b0;
    clearing_o = 1'b0;
    unique case (state_r)
      csrsag_pkg::ST_CLEAR: begin
        clearing_o = 1'b1;
        cnt_we     = 1'b1;
        cnt_waddr  = clr_idx_r;
        cnt_wdata  = '0;
      end
      csrsag_pkg::ST_IDLE: begin
        pop_o = !q_empty_i;
        ld_we = !q_empty_i && (head_cmd == csrsag_pkg::CMD_LOAD);
        rd_en = !q_empty_i && (head_cmd == csrsag_pkg::CMD_WRITE);
      end
      csrsag_pkg::ST_SUM: begin
        cnt_we = 1'b1;
      end
      csrsag_pkg::ST_ADDR: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        clearing_o = 1'b1;
      end
    endcase
  end

  assign clr_idx_nxt   = clearing_o ? clr_idx_r + 1'b1 : clr_idx_r;
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign addr_nxt      = base_i + ADDR_W'({elem_r, csrsag_pkg::VALUE_SHIFT'(0)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csrsag_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // row start table: written by loads, no reset
  always_ff @(posedge clk) begin
    if (ld_we) begin
      start_mem[head_idx] <= head_data;
    end
    if (rd_en) begin
      start_q <= start_mem[head_idx];
    end
  end

  // fill count table: one write port shared by clearing pass and increment
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (rd_en) begin
      cnt_q <= cnt_mem[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_idx_r  <= head_idx;
      cur_data_r <= head_data;
    end
    if (state_r == csrsag_pkg::ST_SUM) begin
      elem_r <= {1'b0, start_q} + {1'b0, cnt_q};
    end
    if (out_load) begin
      out_addr_r <= addr_nxt;
      out_data_r <= cur_data_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_wr_addr    = out_addr_r;
  assign out_write_data = out_data_r;

  property p_result_from_addr;
    @(posedge clk) disable iff (!rst_n)
      $rose(out_valid_r) |-> $past(state_r) == csrsag_pkg::ST_ADDR;
  endproperty
  a_result_from_addr: assert property (p_result_from_addr)
    else $error("result appeared without an address step");

  property p_sum_then_addr;
    @(posedge clk) disable iff (!rst_n)
      state_r == csrsag_pkg::ST_SUM |=> state_r == csrsag_pkg::ST_ADDR;
  endproperty
  a_sum_then_addr: assert property (p_sum_then_addr)
    else $error("sum step not followed by address step");

  property p_no_pop_while_clearing;
    @(posedge clk) disable iff (!rst_n) clearing_o |-> !pop_o;
  endproperty
  a_no_pop_while_clearing: assert property (p_no_pop_while_clearing)
    else $error("queue popped during clearing pass");

  property p_clear_ends;
    @(posedge clk) disable iff (!rst_n)
      (state_r == csrsag_pkg::ST_CLEAR && clr_last) |=> state_r == csrsag_pkg::ST_IDLE;
  endproperty
  a_clear_ends: assert property (p_clear_ends)
    else $error("clearing pass did not end on the last row");

endmodule

>>> rtl/csr_row_scatter_address_gen_core.sv
// ----------------------------------------------------------------------------
// csr_row_scatter_address_gen_core
// Writes: a write passes through the queue, then the read, sum and address
// steps (ST_IDLE, ST_SUM, ST_ADDR) around the fill count table; ST_ADDR waits
// on out_ready, and no new entry is taken until the result is registered. A
// load is taken in ST_IDLE. Reset: synchronous, active low; afterwards a
// clearing pass zeroes the fill counts, and in_ready stays low until it ends.
// ----------------------------------------------------------------------------
// Top level: base address register, input side, queue and address side.
// ----------------------------------------------------------------------------
module csr_row_scatter_address_gen_core #(
  parameter int unsigned ROW_ENTRIES = csrsag_pkg::ROW_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [csrsag_pkg::CMD_W-1:0]   in_cmd,
  input  logic [csrsag_pkg::ROW_W-1:0]   in_row_index,
  input  logic [csrsag_pkg::WORD_W-1:0]  in_row_start,
  input  logic [csrsag_pkg::WORD_W-1:0]  in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [csrsag_pkg::ADDR_W-1:0]  out_wr_addr,
  output logic [csrsag_pkg::WORD_W-1:0]  out_write_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [csrsag_pkg::ADDR_W-1:0]  cfg_base_address
);

  localparam int unsigned ROW_AW  = $clog2(ROW_ENTRIES);
  localparam int unsigned ENTRY_W = csrsag_pkg::CMD_W + ROW_AW + csrsag_pkg::WORD_W;

  logic [csrsag_pkg::ADDR_W-1:0] base_r, base_nxt;
  logic                          push;
  logic [ENTRY_W-1:0]            push_data;
  logic                          pop;
  logic [ENTRY_W-1:0]            head;
  logic                          q_full;
  logic                          q_empty;
  logic                          clearing;

  assign cfg_ready = 1'b1;
  assign base_nxt  = (cfg_valid && cfg_ready) ? cfg_base_address : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else begin
      base_r <= base_nxt;
    end
  end

  csrsag_front #(
    .ROW_ENTRIES (ROW_ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_row_index (in_row_index),
    .in_row_start (in_row_start),
    .in_value     (in_value),
    .q_full_i     (q_full),
    .clearing_i   (clearing),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  csrsag_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (csrsag_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  csrsag_back #(
    .ROW_ENTRIES (ROW_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_i         (head),
    .q_empty_i      (q_empty),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .base_i         (base_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_wr_addr    (out_wr_addr),
    .out_write_data (out_write_data)
  );

endmodule
